>>> src/assert_macros.svh
// Assertion macros shared by the compensation pipeline modules.
// Each macro checks on the rising clock edge and is disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must be followed by a consequence at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ptc_pkg.sv
// Types and constants of the pressure and temperature compensation pipeline.
// Used by the register file, the three pipeline sections and the top level.
package ptc_pkg;

    // Field widths.
    localparam int SAMPLE_W  = 24;
    localparam int CAL_W     = 16;
    localparam int DT_W      = 25;
    localparam int Q_W       = 19;
    localparam int TEMP_W    = 20;
    localparam int WIDE_W    = 42;
    localparam int DD11_W    = 54;
    localparam int T_OUT_W   = 19;
    localparam int P_OUT_W   = 32;

    // Nominal temperature in centi-degrees.
    localparam logic signed [TEMP_W-1:0] TEMP_NOMINAL = 20'sd2000;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_SENS_BASE         = 3'd0,
        REG_OFFSET_BASE       = 3'd1,
        REG_SENS_TEMP_COEFF   = 3'd2,
        REG_OFFSET_TEMP_COEFF = 3'd3,
        REG_TEMP_REFERENCE    = 3'd4,
        REG_TEMP_SLOPE        = 3'd5,
        REG_CAL_VALID         = 3'd6
    } reg_idx_t;

    // Calibration words as seen by the datapath.
    typedef struct packed {
        logic [CAL_W-1:0] sens_base;
        logic [CAL_W-1:0] offset_base;
        logic [CAL_W-1:0] sens_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] temp_reference;
        logic [CAL_W-1:0] temp_slope;
        logic             calibration_valid;
    } cfg_t;

    // Word leaving the first-order section.
    typedef struct packed {
        logic                     ok;
        logic [SAMPLE_W-1:0]      d1;
        logic signed [Q_W-1:0]    q;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
        logic signed [DD11_W-1:0] dd11;
    } front_t;

    // Word leaving the second-order section.
    typedef struct packed {
        logic                     ok;
        logic [SAMPLE_W-1:0]      d1;
        logic signed [TEMP_W-1:0] temp2;
        logic signed [WIDE_W-1:0] x;
        logic signed [WIDE_W-1:0] off2;
    } second_t;

endpackage

>>> src/ptc_regs.sv
// APB register file holding the six calibration words and the valid flag.
// Depends on ptc_pkg for the register indexes and the calibration struct.
module ptc_regs
    import ptc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_SENS_BASE:         cfg_reg.sens_base         <= pwdata[15:0];
                REG_OFFSET_BASE:       cfg_reg.offset_base       <= pwdata[15:0];
                REG_SENS_TEMP_COEFF:   cfg_reg.sens_temp_coeff   <= pwdata[15:0];
                REG_OFFSET_TEMP_COEFF: cfg_reg.offset_temp_coeff <= pwdata[15:0];
                REG_TEMP_REFERENCE:    cfg_reg.temp_reference    <= pwdata[15:0];
                REG_TEMP_SLOPE:        cfg_reg.temp_slope        <= pwdata[15:0];
                REG_CAL_VALID:         cfg_reg.calibration_valid <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (idx)
            REG_SENS_BASE:         prdata = {16'b0, cfg_reg.sens_base};
            REG_OFFSET_BASE:       prdata = {16'b0, cfg_reg.offset_base};
            REG_SENS_TEMP_COEFF:   prdata = {16'b0, cfg_reg.sens_temp_coeff};
            REG_OFFSET_TEMP_COEFF: prdata = {16'b0, cfg_reg.offset_temp_coeff};
            REG_TEMP_REFERENCE:    prdata = {16'b0, cfg_reg.temp_reference};
            REG_TEMP_SLOPE:        prdata = {16'b0, cfg_reg.temp_slope};
            REG_CAL_VALID:         prdata = {31'b0, cfg_reg.calibration_valid};
            default:               prdata = '0;
        endcase
    end

endmodule

>>> src/ptc_front.sv
// First-order section: dT, the four calibration products, TEMP offset, OFF and SENS.
// Three register stages; depends on ptc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptc_front
    import ptc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] in_d1,
    input  logic [SAMPLE_W-1:0] in_d2,
    output logic                out_valid,
    output front_t              out_data,
    input  logic                out_ready
);

    logic [2:0] vld_reg;
    logic [2:0] adv;

    // Stage 1: sample check and dT.
    logic                    ok1_reg, ok1_next;
    logic [SAMPLE_W-1:0]     d1_1_reg;
    logic signed [DT_W-1:0]  dt_reg, dt_next;

    // Stage 2: products of dT.
    logic                      ok2_reg;
    logic [SAMPLE_W-1:0]       d1_2_reg;
    logic signed [WIDE_W-1:0]  mt_reg, mt_next;
    logic signed [WIDE_W-1:0]  moff_reg, moff_next;
    logic signed [WIDE_W-1:0]  msens_reg, msens_next;
    logic signed [2*DT_W-1:0]  mdd_reg, mdd_next;

    // Stage 3: truncated quotients and first-order sums.
    front_t                    f3_reg, f3_next;
    logic signed [WIDE_W-1:0]  mt_adj, moff_adj, msens_adj;
    logic signed [DD11_W-1:0]  mdd_w;

    // A stage moves on when it is empty or the one after it moves on.
    always_comb begin
        adv[2] = !vld_reg[2] || out_ready;
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[2];
    assign out_data  = f3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            if (adv[1]) vld_reg[1] <= vld_reg[0];
            if (adv[2]) vld_reg[2] <= vld_reg[1];
        end
    end

    // Stage 1 logic.
    always_comb begin
        ok1_next = cfg.calibration_valid && (in_d1 != '0) && (in_d2 != '0);
        dt_next  = $signed({1'b0, in_d2}) - $signed({1'b0, cfg.temp_reference, 8'b0});
    end

    // Stage 2 logic: one multiplier per product.
    always_comb begin
        mt_next    = dt_reg * $signed({1'b0, cfg.temp_slope});
        moff_next  = dt_reg * $signed({1'b0, cfg.offset_temp_coeff});
        msens_next = dt_reg * $signed({1'b0, cfg.sens_temp_coeff});
        mdd_next   = dt_reg * dt_reg;
    end

    // Stage 3 logic: divisions by powers of two round toward zero.
    always_comb begin
        mt_adj    = mt_reg + $signed({19'b0, {23{mt_reg[WIDE_W-1]}}});
        moff_adj  = moff_reg + $signed({36'b0, {6{moff_reg[WIDE_W-1]}}});
        msens_adj = msens_reg + $signed({35'b0, {7{msens_reg[WIDE_W-1]}}});
        mdd_w     = DD11_W'(mdd_reg);

        f3_next.ok   = ok2_reg;
        f3_next.d1   = d1_2_reg;
        f3_next.q    = mt_adj[WIDE_W-1:23];
        f3_next.off  = $signed({9'b0, cfg.offset_base, 17'b0})
                     + WIDE_W'($signed(moff_adj[WIDE_W-1:6]));
        f3_next.sens = $signed({10'b0, cfg.sens_base, 16'b0})
                     + WIDE_W'($signed(msens_adj[WIDE_W-1:7]));
        // Eleven times dT squared, as shifts and adds.
        f3_next.dd11 = (mdd_w <<< 3) + (mdd_w <<< 1) + mdd_w;
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ok1_reg  <= ok1_next;
            d1_1_reg <= in_d1;
            dt_reg   <= dt_next;
        end
        if (adv[1]) begin
            ok2_reg   <= ok1_reg;
            d1_2_reg  <= d1_1_reg;
            mt_reg    <= mt_next;
            moff_reg  <= moff_next;
            msens_reg <= msens_next;
            mdd_reg   <= mdd_next;
        end
        if (adv[2]) begin
            f3_reg <= f3_next;
        end
    end

    `ASSERT_NEXT(a_zero_sample_marked, aclk, aresetn, in_valid && in_ready && (in_d1 == '0), vld_reg[0] && !ok1_reg, "zero pressure sample entered as usable")

endmodule

>>> src/ptc_second.sv
// Second-order section: low-temperature corrections, TEMP2 and the corrected terms.
// Three register stages; depends on ptc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptc_second
    import ptc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  front_t  in_data,
    output logic    out_valid,
    output second_t out_data,
    input  logic    out_ready
);

    logic [2:0] vld_reg;
    logic [2:0] adv;

    // Stage 1: square of the temperature deviation and Ti.
    logic                      ok1_reg;
    logic [SAMPLE_W-1:0]       d1_1_reg;
    logic                      low1_reg;
    logic signed [2*Q_W-1:0]   sq_reg, sq_next;
    logic signed [TEMP_W-1:0]  ti_reg, ti_next;
    logic signed [TEMP_W-1:0]  temp_reg, temp_next;
    logic signed [WIDE_W-1:0]  off1_reg, sens1_reg;

    // Stage 2: gated corrections.
    logic                      ok2_reg;
    logic [SAMPLE_W-1:0]       d1_2_reg;
    logic                      low2_reg;
    logic signed [TEMP_W-1:0]  temp2_reg, temp2_next;
    logic signed [WIDE_W-1:0]  offi_reg, offi_next;
    logic signed [WIDE_W-1:0]  sensi_reg, sensi_next;
    logic signed [WIDE_W-1:0]  off2_reg, sens2_reg;
    logic signed [43:0]        sq_w, s31, s63;

    // Stage 3: corrected sensitivity and offset.
    second_t                   s3_reg, s3_next;

    always_comb begin
        adv[2] = !vld_reg[2] || out_ready;
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[2];
    assign out_data  = s3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            if (adv[1]) vld_reg[1] <= vld_reg[0];
            if (adv[2]) vld_reg[2] <= vld_reg[1];
        end
    end

    // Stage 1 logic. The deviation TEMP - 2000 is the truncated quotient itself.
    always_comb begin
        sq_next   = in_data.q * in_data.q;
        ti_next   = $signed({1'b0, in_data.dd11[DD11_W-1:35]});
        temp_next = TEMP_W'(in_data.q) + TEMP_NOMINAL;
    end

    // Stage 2 logic: the corrections apply only below the nominal temperature.
    always_comb begin
        sq_w       = 44'(sq_reg);
        s31        = (sq_w <<< 5) - sq_w;
        s63        = (sq_w <<< 6) - sq_w;
        temp2_next = low1_reg ? (temp_reg - ti_reg) : temp_reg;
        offi_next  = low1_reg ? $signed({1'b0, s31[43:3]}) : '0;
        sensi_next = low1_reg ? $signed({3'b0, s63[43:5]}) : '0;
    end

    // Stage 3 logic.
    always_comb begin
        s3_next.ok    = ok2_reg;
        s3_next.d1    = d1_2_reg;
        s3_next.temp2 = temp2_reg;
        s3_next.x     = sens2_reg - sensi_reg;
        s3_next.off2  = off2_reg - offi_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ok1_reg   <= in_data.ok;
            d1_1_reg  <= in_data.d1;
            low1_reg  <= in_data.q[Q_W-1];
            sq_reg    <= sq_next;
            ti_reg    <= ti_next;
            temp_reg  <= temp_next;
            off1_reg  <= in_data.off;
            sens1_reg <= in_data.sens;
        end
        if (adv[1]) begin
            ok2_reg   <= ok1_reg;
            d1_2_reg  <= d1_1_reg;
            low2_reg  <= low1_reg;
            temp2_reg <= temp2_next;
            offi_reg  <= offi_next;
            sensi_reg <= sensi_next;
            off2_reg  <= off1_reg;
            sens2_reg <= sens1_reg;
        end
        if (adv[2]) begin
            s3_reg <= s3_next;
        end
    end

    `ASSERT_HOLDS(a_warm_no_correction, aclk, aresetn, !(vld_reg[1] && !low2_reg) || ((offi_reg == '0) && (sensi_reg == '0)), "second-order terms applied above nominal temperature")

endmodule

>>> src/ptc_press.sv
// Pressure section: D1 times the corrected sensitivity, scaling and the output register.
// Five register stages, the last one drives the result channel.
// Depends on ptc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptc_press
    import ptc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  second_t             in_data,
    output logic                out_valid,
    output logic                out_res,
    output logic [T_OUT_W-1:0]  out_temp,
    output logic [P_OUT_W-1:0]  out_press,
    input  logic                out_ready
);

    logic [4:0] vld_reg;
    logic [4:0] adv;

    // Stage 1: two partial products of D1 with the split sensitivity.
    logic                      ok1_reg;
    logic signed [TEMP_W-1:0]  t1_reg;
    logic signed [WIDE_W-1:0]  o1_reg;
    logic signed [46:0]        pl_reg, pl_next;
    logic signed [45:0]        ph_reg, ph_next;
    logic signed [DT_W-1:0]    d1_s;

    // Stage 2: partial products joined.
    logic                      ok2_reg;
    logic signed [TEMP_W-1:0]  t2_reg;
    logic signed [WIDE_W-1:0]  o2_reg;
    logic signed [67:0]        prod_reg, prod_next;

    // Stage 3: division by 2^21.
    logic                      ok3_reg;
    logic signed [TEMP_W-1:0]  t3_reg;
    logic signed [WIDE_W-1:0]  o3_reg;
    logic signed [46:0]        q21_reg;
    logic signed [67:0]        prod_adj;

    // Stage 4: offset removed.
    logic                      ok4_reg;
    logic signed [TEMP_W-1:0]  t4_reg;
    logic signed [47:0]        a_reg, a_next;

    // Stage 5: division by 2^15 into the output register.
    logic                      res_reg;
    logic [T_OUT_W-1:0]        temp_out_reg, temp_out_next;
    logic [P_OUT_W-1:0]        press_out_reg, press_out_next;
    logic signed [47:0]        a_adj;

    always_comb begin
        adv[4] = !vld_reg[4] || out_ready;
        adv[3] = !vld_reg[3] || adv[4];
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[4];
    assign out_res   = res_reg;
    assign out_temp  = temp_out_reg;
    assign out_press = press_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            if (adv[1]) vld_reg[1] <= vld_reg[0];
            if (adv[2]) vld_reg[2] <= vld_reg[1];
            if (adv[3]) vld_reg[3] <= vld_reg[2];
            if (adv[4]) vld_reg[4] <= vld_reg[3];
        end
    end

    // Stage 1 logic: low half unsigned, high half signed.
    always_comb begin
        d1_s    = $signed({1'b0, in_data.d1});
        pl_next = d1_s * $signed({1'b0, in_data.x[20:0]});
        ph_next = d1_s * $signed(in_data.x[WIDE_W-1:21]);
    end

    // Stage 2 logic.
    always_comb begin
        prod_next = (68'(ph_reg) <<< 21) + 68'(pl_reg);
    end

    // Stage 3 logic: round toward zero.
    always_comb begin
        prod_adj = prod_reg + $signed({47'b0, {21{prod_reg[67]}}});
    end

    // Stage 4 logic.
    always_comb begin
        a_next = 48'(q21_reg) - 48'(o3_reg);
    end

    // Stage 5 logic: unusable words give zero fields.
    always_comb begin
        a_adj = a_reg + $signed({33'b0, {15{a_reg[47]}}});
        if (ok4_reg) begin
            temp_out_next  = t4_reg[T_OUT_W-1:0];
            press_out_next = a_adj[P_OUT_W+14:15];
        end else begin
            temp_out_next  = '0;
            press_out_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ok1_reg <= in_data.ok;
            t1_reg  <= in_data.temp2;
            o1_reg  <= in_data.off2;
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
        end
        if (adv[1]) begin
            ok2_reg  <= ok1_reg;
            t2_reg   <= t1_reg;
            o2_reg   <= o1_reg;
            prod_reg <= prod_next;
        end
        if (adv[2]) begin
            ok3_reg <= ok2_reg;
            t3_reg  <= t2_reg;
            o3_reg  <= o2_reg;
            q21_reg <= prod_adj[67:21];
        end
        if (adv[3]) begin
            ok4_reg <= ok3_reg;
            t4_reg  <= t3_reg;
            a_reg   <= a_next;
        end
        if (adv[4]) begin
            res_reg       <= ok4_reg;
            temp_out_reg  <= temp_out_next;
            press_out_reg <= press_out_next;
        end
    end

    `ASSERT_NEXT(a_last_stage_drains, aclk, aresetn, vld_reg[3] && adv[4], out_valid, "word lost between scaling and output register")
    `ASSERT_HOLDS(a_invalid_zero, aclk, aresetn, !(out_valid && !out_res) || ((out_temp == '0) && (out_press == '0)), "unusable result carries nonzero fields")

endmodule

>>> src/pressure_temperature_compensation.sv
// Top level of the pressure and temperature compensation block.
// Joins the APB register file and the three pipeline sections; depends on ptc_pkg.
//
// Usage:
// - Calibration words are written over the APB port (register i at byte 4*i)
//   while no sample pair is in flight; pready is always high.
// - s_tdata carries one raw pressure and temperature sample pair per word.
//   A word is taken when s_tvalid and s_tready are both high.
// - m_tdata carries the compensated temperature and pressure, m_tuser the
//   valid flag. An unusable word (calibration not valid or a zero sample)
//   leaves with the flag low and both fields zero.
// - The pipeline has three register stages for the first-order terms, three for
//   the second-order terms and five for the pressure product, its scaling and
//   the output register.
// - Throughput is one word per cycle while the receiver does not stall; each stage
//   holds one word and moves on whenever the next stage is empty or moving.
// - When the receiver stalls, the output register holds its word and the
//   pipeline fills up behind it; s_tready falls only when all stages are full.
// - Reset empties the pipeline and clears all calibration registers.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample input: [23:0] pressure_sample, [47:24] temperature_sample
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // Result output: [18:0] temperature_centi, [50:19] pressure_value, [55:51] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // Result flag: [0] valid_res
    output logic        m_tuser
);

    cfg_t    cfg;
    logic    f_valid, f_ready;
    front_t  f_data;
    logic    s2_valid, s2_ready;
    second_t s2_data;
    logic [T_OUT_W-1:0] temp_out;
    logic [P_OUT_W-1:0] press_out;

    // Calibration registers.
    ptc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // First-order terms.
    ptc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_d1     (s_tdata[23:0]),
        .in_d2     (s_tdata[47:24]),
        .out_valid (f_valid),
        .out_data  (f_data),
        .out_ready (f_ready)
    );

    // Second-order corrections.
    ptc_second u_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (s2_valid),
        .out_data  (s2_data),
        .out_ready (s2_ready)
    );

    // Pressure product, scaling and output register.
    ptc_press u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_res   (m_tuser),
        .out_temp  (temp_out),
        .out_press (press_out),
        .out_ready (m_tready)
    );

    assign m_tdata = {5'b0, press_out, temp_out};

endmodule

>>> tb/pressure_temperature_compensation_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pressure and temperature compensation block.
// Predicts every result word from its own copy of the calibration registers and
// compares it field by field; depends on ptc_pkg and the block's RTL.

// One compensated reading as it leaves the block.
typedef struct packed {
    logic               usable;
    logic signed [18:0] temp_centi;
    logic signed [31:0] pressure;
} reading_t;

class compensation_scoreboard;
    localparam longint NOMINAL_CENTI = 2000;
    localparam longint LOW_TEMP_GAIN = 11;
    localparam longint OFF_LOW_GAIN  = 31;
    localparam longint SENS_LOW_GAIN = 63;

    ptc_pkg::cfg_t cal;
    reading_t      pending_q[$];
    int            errors;

    function new();
        cal    = '0;
        errors = 0;
    endfunction

    // Signed division by 2^k; SystemVerilog division truncates toward zero.
    static function longint div_trunc(longint num, int k);
        return num / (longint'(1) << k);
    endfunction

    // Mirrors an APB write; the written value is masked to the register width.
    function void set_register(logic [4:0] addr, logic [31:0] data);
        if (addr[1:0] == 2'b00) begin
            case (addr[4:2])
                ptc_pkg::REG_SENS_BASE:         cal.sens_base         = data[15:0];
                ptc_pkg::REG_OFFSET_BASE:       cal.offset_base       = data[15:0];
                ptc_pkg::REG_SENS_TEMP_COEFF:   cal.sens_temp_coeff   = data[15:0];
                ptc_pkg::REG_OFFSET_TEMP_COEFF: cal.offset_temp_coeff = data[15:0];
                ptc_pkg::REG_TEMP_REFERENCE:    cal.temp_reference    = data[15:0];
                ptc_pkg::REG_TEMP_SLOPE:        cal.temp_slope        = data[15:0];
                ptc_pkg::REG_CAL_VALID:         cal.calibration_valid = data[0];
                default: ;
            endcase
        end
    endfunction

    // First- and second-order compensation of one sample pair, exact in 64 bits.
    function reading_t compensate(logic [23:0] raw_p, logic [23:0] raw_t);
        reading_t r;
        longint   d1, d2, c1, c2, c3, c4, c5, c6;
        longint   dt, t1, off, sens, ti, offi, sensi, e, sq, t2, p2;
        r = '0;
        if (!cal.calibration_valid || raw_p == 24'd0 || raw_t == 24'd0)
            return r;
        d1 = longint'({40'd0, raw_p});
        d2 = longint'({40'd0, raw_t});
        c1 = longint'({48'd0, cal.sens_base});
        c2 = longint'({48'd0, cal.offset_base});
        c3 = longint'({48'd0, cal.sens_temp_coeff});
        c4 = longint'({48'd0, cal.offset_temp_coeff});
        c5 = longint'({48'd0, cal.temp_reference});
        c6 = longint'({48'd0, cal.temp_slope});

        dt   = d2 - (c5 << 8);
        t1   = NOMINAL_CENTI + div_trunc(dt * c6, 23);
        off  = (c2 << 17) + div_trunc(c4 * dt, 6);
        sens = (c1 << 16) + div_trunc(c3 * dt, 7);

        // The low-temperature correction applies only below the nominal point.
        ti    = 0;
        offi  = 0;
        sensi = 0;
        if (t1 < NOMINAL_CENTI) begin
            e     = t1 - NOMINAL_CENTI;
            sq    = e * e;
            ti    = div_trunc(LOW_TEMP_GAIN * dt * dt, 35);
            offi  = div_trunc(OFF_LOW_GAIN * sq, 3);
            sensi = div_trunc(SENS_LOW_GAIN * sq, 5);
        end

        t2 = t1 - ti;
        p2 = div_trunc(div_trunc(d1 * (sens - sensi), 21) - (off - offi), 15);
        r.usable     = 1'b1;
        r.temp_centi = t2[18:0];
        r.pressure   = p2[31:0];
        return r;
    endfunction

    function void note_sample(logic [23:0] raw_p, logic [23:0] raw_t);
        pending_q.push_back(compensate(raw_p, raw_t));
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction

    task report(string msg);
        if (errors < 100)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // Compares one accepted result word with the oldest expectation.
    task check_word(logic flag, logic [55:0] data);
        reading_t want, got;
        got.usable     = flag;
        got.temp_centi = data[18:0];
        got.pressure   = data[50:19];
        if (pending_q.size() == 0) begin
            report("result word arrived with nothing expected");
            return;
        end
        want = pending_q.pop_front();
        if (got.usable !== want.usable)
            report($sformatf("valid_res got %b want %b", got.usable, want.usable));
        if (got.temp_centi !== want.temp_centi)
            report($sformatf("temperature_centi got %0d want %0d",
                             got.temp_centi, want.temp_centi));
        if (got.pressure !== want.pressure)
            report($sformatf("pressure_value got %0d want %0d",
                             got.pressure, want.pressure));
    endtask
endclass

module pressure_temperature_compensation_test;
    import ptc_pkg::*;

    localparam int          PIPE_LATENCY  = 11;
    localparam int          SETTLE_CYCLES = 2 * PIPE_LATENCY;
    localparam int          PHASE_WORDS   = 250;
    localparam int          NUM_PHASES    = 7;
    localparam logic [4:0]  UNMAPPED_ADDR = 5'd28;
    localparam logic [23:0] SAMPLE_MAX    = 24'hFFFFFF;

    // Typical calibration words of a production part.
    localparam logic [15:0] TYP_C1 = 16'd34982;
    localparam logic [15:0] TYP_C2 = 16'd36352;
    localparam logic [15:0] TYP_C3 = 16'd20328;
    localparam logic [15:0] TYP_C4 = 16'd22354;
    localparam logic [15:0] TYP_C5 = 16'd26646;
    localparam logic [15:0] TYP_C6 = 16'd26146;
    localparam logic [23:0] TYP_D1 = 24'd4311550;
    localparam logic [23:0] TYP_D2 = 24'd8077636;
    // Raw temperature at which dT is zero for the typical words.
    localparam logic [23:0] TYP_REF_D2 = 24'd6821376;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [23:0] pressure_sample, [47:24] temperature_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [18:0] temperature_centi, [50:19] pressure_value, [55:51] zero
    logic        m_tuser;   // [0] valid_res

    compensation_scoreboard board;
    int source_idle_pct = 0;
    int sink_stall_pct  = 0;

    pressure_temperature_compensation DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // APB write: setup phase, access phase, then an idle phase.
    task automatic write_register(logic [4:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_register(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes all calibration words; the upper data bits are random to test masking.
    task automatic load_calibration(logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
                                    logic [15:0] c4, logic [15:0] c5, logic [15:0] c6,
                                    logic usable);
        write_register({REG_SENS_BASE, 2'b00},         {16'($urandom), c1});
        write_register({REG_OFFSET_BASE, 2'b00},       {16'($urandom), c2});
        write_register({REG_SENS_TEMP_COEFF, 2'b00},   {16'($urandom), c3});
        write_register({REG_OFFSET_TEMP_COEFF, 2'b00}, {16'($urandom), c4});
        write_register({REG_TEMP_REFERENCE, 2'b00},    {16'($urandom), c5});
        write_register({REG_TEMP_SLOPE, 2'b00},        {16'($urandom), c6});
        write_register({REG_CAL_VALID, 2'b00},         {31'($urandom), usable});
    endtask

    // Offers one sample pair, optionally after an idle burst, until it is taken.
    task automatic send_sample(logic [23:0] raw_p, logic [23:0] raw_t);
        if (source_idle_pct != 0 && $urandom_range(0, 99) < source_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_t, raw_p};
        do @(posedge aclk); while (!s_tready);
        board.note_sample(raw_p, raw_t);
    endtask

    // Stops the source and waits until every expected word has come back.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random sample pair: mostly around the reference temperature or uniform,
    // now and then with a zero sample.
    function automatic logic [47:0] random_pair(logic [15:0] ref_word);
        int unsigned roll;
        longint      span, t_val;
        logic [23:0] raw_p, raw_t;
        roll  = $urandom_range(0, 99);
        raw_p = 24'($urandom);
        raw_t = 24'($urandom);
        if (roll < 4) begin
            raw_p = 24'd0;
        end else if (roll < 8) begin
            raw_t = 24'd0;
        end else if (roll < 55) begin
            span  = longint'(1) << $urandom_range(2, 22);
            t_val = (longint'({48'd0, ref_word}) << 8)
                  + longint'($urandom_range(0, 32'(2 * span))) - span;
            if (t_val < 1)
                t_val = 1;
            if (t_val > longint'({40'd0, SAMPLE_MAX}))
                t_val = longint'({40'd0, SAMPLE_MAX});
            raw_t = t_val[23:0];
        end
        return {raw_t, raw_p};
    endfunction

    // Result side: random stall bursts while sink_stall_pct is nonzero.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Every accepted result word goes to the checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_word(m_tuser, m_tdata);
    end

    // Stimulus: reset, directed cases, then randomized calibration phases.
    initial begin
        logic [47:0] pair;
        int unsigned pick;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        board = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Calibration after reset is not usable, so words leave flagged off.
        source_idle_pct = 20;
        sink_stall_pct  = 20;
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(24'd1, 24'd1);
        quiesce();

        // Directed cases with typical calibration words.
        load_calibration(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 1'b1);
        send_sample(24'd0, TYP_D2);
        send_sample(TYP_D1, 24'd0);
        send_sample(24'd0, 24'd0);
        send_sample(TYP_D1, TYP_D2);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(24'd1, 24'd1);
        send_sample(SAMPLE_MAX, 24'd1);
        send_sample(24'd1, SAMPLE_MAX);
        // Around dT = 0, and where TEMP first drops below the nominal point.
        send_sample(TYP_D1, TYP_REF_D2);
        send_sample(TYP_D1, TYP_REF_D2 - 24'd1);
        send_sample(TYP_D1, TYP_REF_D2 + 24'd1);
        send_sample(TYP_D1, TYP_REF_D2 - 24'd320);
        send_sample(TYP_D1, TYP_REF_D2 - 24'd321);
        // Deep in the low-temperature region.
        send_sample(TYP_D1, TYP_REF_D2 - 24'd3000000);
        send_sample(SAMPLE_MAX, 24'd2);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            quiesce();
            case (phase)
                0: load_calibration(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 1'b1);
                1: load_calibration('1, '1, '1, '1, '1, '1, 1'b1);
                2: load_calibration('0, '0, '0, '0, '0, '0, 1'b1);
                3: load_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
                4: load_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
                5: begin
                    // Steep slope and a mid reference give large low-temperature terms.
                    load_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'h8000, '1, 1'b1);
                    write_register(UNMAPPED_ADDR, $urandom);
                end
                default:
                    load_calibration(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 1'b1);
            endcase

            // The last phase runs at full rate on both sides.
            if (phase == NUM_PHASES - 1) begin
                source_idle_pct = 0;
                sink_stall_pct  = 0;
            end else begin
                pick = $urandom_range(0, 2);
                source_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
                pick = $urandom_range(0, 2);
                sink_stall_pct  = (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
            end

            repeat (PHASE_WORDS) begin
                pair = random_pair(board.cal.temp_reference);
                send_sample(pair[23:0], pair[47:24]);
            end
        end

        quiesce();
        if (board.errors == 0 && board.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #12_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/ptc_pkg.sv
src/ptc_regs.sv
src/ptc_front.sv
src/ptc_second.sv
src/ptc_press.sv
src/pressure_temperature_compensation.sv
tb/pressure_temperature_compensation_test.sv
